// File: hdl/swv_pkg.sv
// Package for the sliding window variance block: field widths, stream widths
// and the payload types shared by the design. No dependencies.
`default_nettype none

package swv_pkg;

   // field widths
   localparam int SAMPLE_W = 10;
   localparam int SQ_W     = 2 * SAMPLE_W;
   localparam int SUM_W    = 16;
   localparam int SUMSQ_W  = 26;
   localparam int VAR_W    = 19;

   // stream data widths, whole bytes
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [SQ_W-1:0]     square_type;
   typedef logic [SUM_W-1:0]    sum_type;
   typedef logic [SUMSQ_W-1:0]  sumsq_type;
   typedef logic [VAR_W-1:0]    var_type;

endpackage

`default_nettype wire

// File: hdl/swv_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module swv_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 48
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  logic [WIDTH-1:0]                wr_data,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic [WIDTH-1:0]                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/sliding_window_variance.sv
// rsp_tvalid rises once a sample accepted into the input register has passed the totals update,
// the numerator and the reciprocal-multiply divide into the result register.
// Throughput: one sample per cycle; every stage holds its transaction while the
// next one is full, and empty stages keep filling while a result waits.
// Reset clears all valid flags, the running totals, the write position and the
// per-entry valid bits of the sample ring; no clearing pass, ready right away.
`default_nettype none

// Top level: sliding window variance over the last WINDOW samples.
// Depends on swv_pkg and swv_ram.
module sliding_window_variance
   import swv_pkg::*;
#(
   parameter int WINDOW = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   // input stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [9:0] sample, rest zero
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // [18:0] variance, [34:19] window_sum
);

   localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int PROD_W   = SUMSQ_W + $clog2(WINDOW + 1);
   localparam int NUM_W    = (PROD_W > 2 * SUM_W) ? PROD_W : 2 * SUM_W;
   localparam int DEN      = WINDOW * (WINDOW - 1);
   localparam int SHIFT    = NUM_W + $clog2(DEN);
   localparam int QP_W     = 2 * NUM_W + 1;
   localparam int PAD_W    = RSP_TDATA_W - VAR_W - SUM_W;
   localparam int SUM_MAX  = WINDOW * ((1 << SAMPLE_W) - 1);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW - 1);
   // ceil(2^SHIFT / DEN): exact floor division for any NUM_W-bit numerator
   localparam logic [NUM_W:0] RECIP =
      (NUM_W + 1)'(((64'd1 << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN));

   // input register
   logic       in_vld_ff;
   sample_type in_sample_ff;
   logic       in_rdy;

   // running totals and ring control
   logic              tot_vld_ff;
   logic              tot_rdy;
   sum_type           sum_ff, sum_in;
   sumsq_type         sumsq_ff, sumsq_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [WINDOW-1:0] ring_vld_ff;
   logic              upd;
   sample_type        stale_raw, stale;
   square_type        fresh_sq, stale_sq;

   // numerator stage
   logic              num_vld_ff;
   logic              num_rdy;
   logic [NUM_W-1:0]  num_ff, num_in;
   sum_type           num_sum_ff;
   logic [NUM_W-1:0]  prod;
   logic [NUM_W-1:0]  sq;

   // result register
   logic              res_vld_ff;
   logic              res_rdy;
   var_type           res_var_ff;
   sum_type           res_sum_ff;
   logic [QP_W-1:0]   quo_prod;
   var_type           quo;

   // ready chain, output side back to input side
   assign res_rdy    = !res_vld_ff || rsp_tready;
   assign num_rdy    = !num_vld_ff || res_rdy;
   assign tot_rdy    = !tot_vld_ff || num_rdy;
   assign in_rdy     = !in_vld_ff || tot_rdy;
   assign req_tready = in_rdy;

   // ring storage; the oldest entry is read ahead so it is ready at update
   swv_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (upd && !reset),
      .wr_addr (pos_ff),
      .wr_data (in_sample_ff),
      .rd_addr (reset ? '0 : pos_in),
      .rd_data (stale_raw)
   );

   // totals update: add the new sample, drop the oldest
   assign upd      = in_vld_ff && tot_rdy;
   assign stale    = ring_vld_ff[pos_ff] ? stale_raw : '0;
   assign fresh_sq = SQ_W'(in_sample_ff) * SQ_W'(in_sample_ff);
   assign stale_sq = SQ_W'(stale) * SQ_W'(stale);
   assign sum_in   = sum_ff + SUM_W'(in_sample_ff) - SUM_W'(stale);
   assign sumsq_in = sumsq_ff + SUMSQ_W'(fresh_sq) - SUMSQ_W'(stale_sq);

   always_comb begin
      pos_in = pos_ff;
      if (upd) begin
         pos_in = (pos_ff == LAST_POS) ? '0 : pos_ff + POS_W'(1);
      end
   end

   // numerator: WINDOW*sum_sq - sum^2, floored at zero
   assign prod   = NUM_W'(sumsq_ff) * NUM_W'(WINDOW);
   assign sq     = NUM_W'(sum_ff) * NUM_W'(sum_ff);
   assign num_in = (prod >= sq) ? prod - sq : '0;

   // divide by the constant WINDOW*(WINDOW-1) as a multiply by its reciprocal
   assign quo_prod = QP_W'(num_ff) * QP_W'(RECIP);
   assign quo      = quo_prod[SHIFT +: VAR_W];

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         tot_vld_ff  <= 1'b0;
         num_vld_ff  <= 1'b0;
         res_vld_ff  <= 1'b0;
         sum_ff      <= '0;
         sumsq_ff    <= '0;
         pos_ff      <= '0;
         ring_vld_ff <= '0;
      end else begin
         if (in_rdy) begin
            in_vld_ff <= req_tvalid;
         end
         if (tot_rdy) begin
            tot_vld_ff <= in_vld_ff;
         end
         if (upd) begin
            sum_ff              <= sum_in;
            sumsq_ff            <= sumsq_in;
            ring_vld_ff[pos_ff] <= 1'b1;
         end
         pos_ff <= pos_in;
         if (num_rdy) begin
            num_vld_ff <= tot_vld_ff;
         end
         if (res_rdy) begin
            res_vld_ff <= num_vld_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_rdy) begin
         in_sample_ff <= req_tdata[SAMPLE_W-1:0];
      end
      if (num_rdy) begin
         num_ff     <= num_in;
         num_sum_ff <= sum_ff;
      end
      if (res_rdy) begin
         res_var_ff <= quo;
         res_sum_ff <= num_sum_ff;
      end
   end

   // result stream
   assign rsp_tvalid = res_vld_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, res_sum_ff, res_var_ff};

`ifndef SYNTHESIS
   // window sum can never exceed a full window of maximum samples
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      32'(sum_ff) <= 32'(SUM_MAX))
      else $error("window sum above its bound");

   // totals stay consistent: sum^2 <= WINDOW * sum of squares
   a_totals_consistent: assert property (@(posedge clock) disable iff (reset)
      sq <= prod)
      else $error("running totals inconsistent");

   // totals and position move only on an update
   a_totals_hold: assert property (@(posedge clock) disable iff (reset)
      !upd |=> $stable(sum_ff) && $stable(sumsq_ff) && $stable(pos_ff))
      else $error("totals changed without an update");

   // write position stays inside the ring
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("write position out of range");

   // a stalled result stays put until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire

// File: tb/sliding_window_variance_checker.sv
// Checker for the sliding window variance block: watches both streams, predicts
// each result from the accepted samples and compares. Depends on swv_pkg.
`timescale 1ns / 1ps

module sliding_window_variance_checker
   import swv_pkg::*;
#(
   parameter int WINDOW = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [9:0] sample, rest zero
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,   // [18:0] variance, [34:19] window_sum
   output int                     fail_count,
   output int                     pending,
   output int                     result_count
);

   typedef struct packed {
      var_type variance;
      sum_type window_sum;
   } window_stats_t;

   // own copy of the window state
   sample_type    history [WINDOW];
   int            slot;
   sum_type       total;
   sumsq_type     total_sq;
   window_stats_t stats_due [$];

   initial begin
      fail_count   = 0;
      pending      = 0;
      result_count = 0;
   end

   // Overwrite the oldest sample, update both totals, work out the variance
   function automatic window_stats_t advance_window(input sample_type fresh);
      sample_type    stale;
      logic [63:0]   numer;
      logic [63:0]   sum_squared;
      logic [63:0]   quot;
      window_stats_t r;
      stale         = history[slot];
      history[slot] = fresh;
      slot          = (slot == WINDOW - 1) ? 0 : slot + 1;
      total         = sum_type'(64'(total) + 64'(fresh) - 64'(stale));
      total_sq      = sumsq_type'(64'(total_sq) + 64'(fresh) * 64'(fresh)
                                  - 64'(stale) * 64'(stale));
      numer         = 64'(WINDOW) * 64'(total_sq);
      sum_squared   = 64'(total) * 64'(total);
      numer         = (numer >= sum_squared) ? numer - sum_squared : 64'd0;
      quot          = numer / (64'(WINDOW) * 64'(WINDOW - 1));
      r.variance    = var_type'(quot);
      r.window_sum  = total;
      return r;
   endfunction

   always @(posedge clock) begin
      window_stats_t want;
      window_stats_t got;
      if (reset) begin
         foreach (history[i]) history[i] = '0;
         slot     = 0;
         total    = '0;
         total_sq = '0;
         stats_due.delete();
      end else begin
         // result transaction: compare with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            got.variance   = rsp_tdata[VAR_W-1:0];
            got.window_sum = rsp_tdata[VAR_W +: SUM_W];
            if (stats_due.size() == 0) begin
               if (fail_count < 10)
                  $display("[%0t] unexpected result: variance %0d window_sum %0d",
                           $realtime, got.variance, got.window_sum);
               fail_count++;
            end else begin
               want = stats_due.pop_front();
               if (got.variance !== want.variance || got.window_sum !== want.window_sum) begin
                  if (fail_count < 10)
                     $display("[%0t] mismatch: variance exp %0d got %0d, window_sum exp %0d got %0d",
                              $realtime, want.variance, got.variance,
                              want.window_sum, got.window_sum);
                  fail_count++;
               end
            end
         end
         // sample transaction: predict its result
         if (req_tvalid && req_tready)
            stats_due.push_back(advance_window(req_tdata[SAMPLE_W-1:0]));
      end
      pending = stats_due.size();
   end

endmodule

// File: tb/sliding_window_variance_tb.sv
// Testbench top for the sliding window variance block: clock, reset, sample
// stimulus and back-pressure, verdict. Depends on swv_pkg and the checker.
`timescale 1ns / 1ps

module sliding_window_variance_tb;
   import swv_pkg::*;

   localparam int WINDOW         = 48;
   localparam int PHASE_ITEMS    = 332;
   localparam int TAIL_CYCLES    = 44;   // well past the pipeline depth
   localparam int WATCHDOG_LIMIT = 3000;

   typedef enum int {
      PAT_UNIFORM,
      PAT_FULL_SCALE,
      PAT_ZERO,
      PAT_SWING,
      PAT_NARROW,
      PAT_ONE_HOT
   } pattern_e;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int fail_count;
   int pending;
   int result_count;
   int idle_pct     = 0;
   int stall_pct    = 0;
   int samples_sent = 0;
   int quiet_cycles = 0;

   sliding_window_variance #(.WINDOW(WINDOW)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sliding_window_variance_checker #(.WINDOW(WINDOW)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .fail_count   (fail_count),
      .pending      (pending),
      .result_count (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog: cycles without any transaction on either stream
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // one sample transaction, with random idle cycles ahead of it
   task automatic drive_sample(input sample_type s);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - SAMPLE_W){1'b0}}, s};
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   // hold the sender off until every predicted result has come back
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   function automatic sample_type pattern_sample(input pattern_e pat, input int idx,
                                                 input sample_type base);
      case (pat)
         PAT_FULL_SCALE: return sample_type'(1023);
         PAT_ZERO:       return sample_type'(0);
         PAT_SWING:      return (idx % 2 == 0) ? sample_type'(1023) : sample_type'(0);
         PAT_NARROW:     return sample_type'(base ^ sample_type'($urandom_range(7)));
         PAT_ONE_HOT:    return sample_type'(1 << $urandom_range(SAMPLE_W - 1));
         default:        return sample_type'($urandom_range(1023));
      endcase
   endfunction

   initial begin
      sample_type directed [] = '{10'd0, 10'd1023, 10'd1023, 10'd0, 10'd1,
                                  10'd512, 10'd511, 10'h155, 10'h2AA, 10'd1023,
                                  10'd0, 10'd1023, 10'd0, 10'd1022, 10'd2,
                                  10'd1023, 10'd1023, 10'd1023, 10'd0, 10'd768};
      pattern_e   pat;
      sample_type base;
      int         burst;
      int         left;

      // hold the synchronous reset, then release it
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes while the window is still filling
      foreach (directed[i]) drive_sample(directed[i]);

      // random phases: free flow, sender idling, receiver stalling, both
      for (int phase = 0; phase < 4; phase++) begin
         drain_results();
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 60; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 60; end
            default: begin idle_pct = 37; stall_pct = 37; end
         endcase
         left = PHASE_ITEMS;
         while (left > 0) begin
            pat   = pattern_e'($urandom_range(PAT_ONE_HOT));
            base  = sample_type'($urandom_range(1023));
            burst = $urandom_range(WINDOW / 2, 2 * WINDOW);
            if (burst > left) burst = left;
            for (int k = 0; k < burst; k++) drive_sample(pattern_sample(pat, k, base));
            left -= burst;
         end
      end

      // wind down
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d samples (%0d results checked) over a window of %0d,",
               samples_sent, result_count, WINDOW);
      $display("free flow, sender idling, receiver stalling and both together.");
      if (fail_count == 0 && pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: filelist.f
hdl/swv_pkg.sv
hdl/swv_ram.sv
hdl/sliding_window_variance.sv
tb/sliding_window_variance_checker.sv
tb/sliding_window_variance_tb.sv
